[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the impulse detector blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define EID_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[src/eid_pkg.sv]
// ----------------------------------------------------------------------------
// eid_pkg
// shared types and constants for the emg impulse detector
// ----------------------------------------------------------------------------
package eid_pkg;

   localparam int WINDOW_LEN  = 16;
   localparam int CHANNELS    = 8;
   localparam int QUEUE_DEPTH = 4;

   // level word widths cover the whole window length range
   localparam int LVL_SUM_W = 16;
   localparam int LVL_CNT_W = 9;

   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int LEVEL_W   = 12;
   localparam int COUNT8_W  = 8;

   localparam logic [CSR_IDX_W-1:0] REG_RISE_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE  = 3'd5;

   localparam logic [LEVEL_W-1:0]  RISE_HIGH_RST = 12'd1024;
   localparam logic [LEVEL_W-1:0]  RISE_LOW_RST  = 12'd512;
   localparam logic [LEVEL_W-1:0]  FALL_HIGH_RST = 12'd1024;
   localparam logic [LEVEL_W-1:0]  FALL_LOW_RST  = 12'd512;
   localparam logic [COUNT8_W-1:0] PULSE_LEN_RST = 8'd10;
   localparam logic [COUNT8_W-1:0] DEBOUNCE_RST  = 8'd5;

   typedef struct packed {
      logic signed [7:0] chan0;
      logic signed [7:0] chan1;
      logic signed [7:0] chan2;
      logic signed [7:0] chan3;
      logic signed [7:0] chan4;
      logic signed [7:0] chan5;
      logic signed [7:0] chan6;
      logic signed [7:0] chan7;
      logic              posing;
   } eid_req_type;

   typedef struct packed {
      logic impulse;
      logic rising_pulse;
      logic falling_pulse;
   } eid_rsp_type;

   typedef struct packed {
      logic                 posing;
      logic [LVL_SUM_W-1:0] max_sum;
      logic [LVL_CNT_W-1:0] count;
   } eid_level_type;

   typedef struct packed {
      logic not_empty;
      logic room_one;
      logic room_two;
   } eid_q_status_type;

endpackage

[src/eid_front.sv]
// ----------------------------------------------------------------------------
// eid_front
// rectifies each frame, keeps the sliding window and per-channel sums, and
// produces the peak channel sum and frame count for the detectors
// ----------------------------------------------------------------------------
module eid_front #(
   parameter int WINDOW_LEN = eid_pkg::WINDOW_LEN,
   parameter int CHANNELS   = eid_pkg::CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  eid_pkg::eid_req_type      req_data,
   input  eid_pkg::eid_q_status_type q_status,
   output logic                      push,
   output eid_pkg::eid_level_type    push_data
);

   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = $clog2(128 * WINDOW_LEN + 1);
   localparam int MEM_W  = 8 * CHANNELS;

   logic [MEM_W-1:0]  window_mem [WINDOW_LEN];
   logic [MEM_W-1:0]  rd_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in, rd_addr;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sums_ff [CHANNELS];
   logic [SUM_W-1:0]  sums_in [CHANNELS];
   logic              s1_valid_ff;
   logic              s1_posing_ff;
   logic [7:0]        samp [8];
   logic [7:0]        mag [CHANNELS];
   logic [MEM_W-1:0]  wdata;
   logic              accept, full;
   logic [SUM_W-1:0]  max_sum;

   assign samp[0] = req_data.chan0;
   assign samp[1] = req_data.chan1;
   assign samp[2] = req_data.chan2;
   assign samp[3] = req_data.chan3;
   assign samp[4] = req_data.chan4;
   assign samp[5] = req_data.chan5;
   assign samp[6] = req_data.chan6;
   assign samp[7] = req_data.chan7;

   assign req_stall = s1_valid_ff ? !q_status.room_two : !q_status.room_one;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == CNT_W'(WINDOW_LEN));

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mag[c] = samp[c][7] ? (~samp[c] + 8'd1) : samp[c];
         wdata[8*c +: 8] = mag[c];
         sums_in[c] = sums_ff[c] - (full ? SUM_W'(rd_ff[8*c +: 8]) : '0) + SUM_W'(mag[c]);
      end
   end

   always_comb begin
      slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      rd_addr = accept ? slot_in : slot_ff;
   end

   // window storage with one registered read port, prefetching the next slot
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[slot_ff] <= wdata;
      end
      if (accept && (slot_ff == rd_addr)) begin
         rd_ff <= wdata;
      end else begin
         rd_ff <= window_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            for (int c = 0; c < CHANNELS; c++) begin
               sums_ff[c] <= sums_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_posing_ff <= req_data.posing;
      end
   end

   // peak over the updated sums
   always_comb begin
      max_sum = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (sums_ff[c] > max_sum) begin
            max_sum = sums_ff[c];
         end
      end
   end

   assign push              = s1_valid_ff;
   assign push_data.posing  = s1_posing_ff;
   assign push_data.max_sum = eid_pkg::LVL_SUM_W'(max_sum);
   assign push_data.count   = eid_pkg::LVL_CNT_W'(fill_ff);

endmodule

[src/eid_queue.sv]
// ----------------------------------------------------------------------------
// eid_queue
// short fifo of level words between the window front and the detectors
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eid_queue #(
   parameter int DEPTH = eid_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  eid_pkg::eid_level_type    push_data,
   input  logic                      pop,
   output eid_pkg::eid_level_type    head_data,
   output eid_pkg::eid_q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   eid_pkg::eid_level_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head_data          = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.room_one  = (count_ff < CNT_W'(DEPTH));
   assign q_status.room_two  = (count_ff < CNT_W'(DEPTH - 1));

   `EID_ASSERT(a_q_no_overflow, clock, reset, push |-> (count_ff < CNT_W'(DEPTH)), "queue push while full")
   `EID_ASSERT_NEVER(a_q_no_underflow, clock, reset, pop && (count_ff == '0), "queue pop while empty")

endmodule

[src/eid_back.sv]
// ----------------------------------------------------------------------------
// eid_back
// threshold registers, rising and falling impulse detectors, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eid_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [eid_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [eid_pkg::CSR_W-1:0]              csr_wdata,
   input  logic                                   head_valid,
   input  eid_pkg::eid_level_type                 head_data,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output eid_pkg::eid_rsp_type                   rsp_data
);

   localparam int PROD_W = eid_pkg::LEVEL_W + eid_pkg::LVL_CNT_W;
   localparam int CW     = eid_pkg::COUNT8_W;

   logic [eid_pkg::LEVEL_W-1:0] rise_high_ff, rise_low_ff, fall_high_ff, fall_low_ff;
   logic [CW-1:0]               pulse_len_ff, debounce_ff;

   logic          rise_active_ff, rise_active_in;
   logic [CW-1:0] rise_rem_ff, rise_rem_in;
   logic          fall_active_ff, fall_active_in;
   logic [CW-1:0] fall_rem_ff, fall_rem_in;
   logic [CW-1:0] rise_conf_ff, rise_conf_in;
   logic [CW-1:0] fall_conf_ff, fall_conf_in;

   logic                 rsp_valid_ff;
   eid_pkg::eid_rsp_type rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0] lhs, cnt, p_rise_high, p_rise_low, p_fall_high, p_fall_low;
   logic              load;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_high_ff <= eid_pkg::RISE_HIGH_RST;
         rise_low_ff  <= eid_pkg::RISE_LOW_RST;
         fall_high_ff <= eid_pkg::FALL_HIGH_RST;
         fall_low_ff  <= eid_pkg::FALL_LOW_RST;
         pulse_len_ff <= eid_pkg::PULSE_LEN_RST;
         debounce_ff  <= eid_pkg::DEBOUNCE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            eid_pkg::REG_RISE_HIGH: rise_high_ff <= csr_wdata;
            eid_pkg::REG_RISE_LOW:  rise_low_ff  <= csr_wdata;
            eid_pkg::REG_FALL_HIGH: fall_high_ff <= csr_wdata;
            eid_pkg::REG_FALL_LOW:  fall_low_ff  <= csr_wdata;
            eid_pkg::REG_PULSE_LEN: pulse_len_ff <= csr_wdata[CW-1:0];
            eid_pkg::REG_DEBOUNCE:  debounce_ff  <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // level compare: max_sum*16 against threshold*count
   always_comb begin
      lhs         = PROD_W'({head_data.max_sum, 4'b0000});
      cnt         = PROD_W'(head_data.count);
      p_rise_high = PROD_W'(rise_high_ff) * cnt;
      p_rise_low  = PROD_W'(rise_low_ff) * cnt;
      p_fall_high = PROD_W'(fall_high_ff) * cnt;
      p_fall_low  = PROD_W'(fall_low_ff) * cnt;
   end

   always_comb begin
      rise_active_in = rise_active_ff;
      rise_rem_in    = rise_rem_ff;
      fall_active_in = fall_active_ff;
      fall_rem_in    = fall_rem_ff;
      rise_conf_in   = rise_conf_ff;
      fall_conf_in   = fall_conf_ff;
      rsp_data_in    = '0;

      // rising detector with hysteresis
      if (!rise_active_in && (lhs > p_rise_high) && !head_data.posing) begin
         rise_active_in = 1'b1;
         rise_rem_in    = pulse_len_ff;
      end
      if (rise_active_in && (rise_rem_in != '0)) begin
         rsp_data_in.rising_pulse = 1'b1;
         rise_rem_in = rise_rem_in - 1'b1;
      end
      if ((rise_rem_in == '0) && (lhs <= p_rise_low)) begin
         rise_active_in = 1'b0;
      end

      // falling detector with debounce
      if (lhs >= p_fall_high) begin
         if (rise_conf_in != '0) begin
            rise_conf_in = rise_conf_in - 1'b1;
         end
      end else begin
         rise_conf_in = debounce_ff;
      end
      if (rise_conf_in == '0) begin
         fall_active_in = 1'b1;
      end
      if (lhs <= p_fall_low) begin
         if (fall_conf_in != '0) begin
            fall_conf_in = fall_conf_in - 1'b1;
         end
      end else begin
         fall_conf_in = debounce_ff;
      end
      if (fall_active_in && (fall_conf_in == '0)) begin
         fall_active_in = 1'b0;
         fall_rem_in    = pulse_len_ff;
      end
      if (!fall_active_in && (fall_rem_in != '0)) begin
         rsp_data_in.falling_pulse = 1'b1;
         fall_rem_in = fall_rem_in - 1'b1;
      end

      rsp_data_in.impulse = rsp_data_in.rising_pulse || rsp_data_in.falling_pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_active_ff <= 1'b0;
         rise_rem_ff    <= '0;
         fall_active_ff <= 1'b0;
         fall_rem_ff    <= '0;
         rise_conf_ff   <= eid_pkg::DEBOUNCE_RST;
         fall_conf_ff   <= eid_pkg::DEBOUNCE_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (load) begin
            rise_active_ff <= rise_active_in;
            rise_rem_ff    <= rise_rem_in;
            fall_active_ff <= fall_active_in;
            fall_rem_ff    <= fall_rem_in;
            rise_conf_ff   <= rise_conf_in;
            fall_conf_ff   <= fall_conf_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EID_ASSERT(a_fall_pulse_idle, clock, reset, load |=> !(rsp_data_ff.falling_pulse && fall_active_ff), "falling pulse while fall detector armed")

endmodule

[src/emg_impulse_detector.sv]
// throughput: one word per cycle while the queue has room and rsp is not stalled
// the window memory read is prefetched one slot ahead, so it never holds up an accepted word
// reset: synchronous, active high; clears sums, counters and detector state and
// loads the threshold registers with their defaults; window memory is not cleared
// ----------------------------------------------------------------------------
// emg_impulse_detector
// moving-average envelope impulse detector over eight emg channels
// ----------------------------------------------------------------------------
module emg_impulse_detector #(
   parameter int WINDOW_LEN  = eid_pkg::WINDOW_LEN,
   parameter int CHANNELS    = eid_pkg::CHANNELS,
   parameter int QUEUE_DEPTH = eid_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  eid_pkg::eid_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output eid_pkg::eid_rsp_type          rsp_data,
   input  logic                          csr_wr_en,
   input  logic [eid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eid_pkg::CSR_W-1:0]     csr_wdata
);

   eid_pkg::eid_q_status_type q_status;
   eid_pkg::eid_level_type    push_data, head_data;
   logic                      push, pop;

   eid_front #(
      .WINDOW_LEN (WINDOW_LEN),
      .CHANNELS   (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   eid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   eid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (q_status.not_empty),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[bench/emg_impulse_detector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_impulse_detector_test
// drives emg frames through the impulse detector and checks every pulse
// word against a cycle-free envelope predictor kept in step with the
// register writes, or against a typed row's word; a short drill table
// covers extremes and corner settings, then phases of burst-shaped random
// frames run under random settings with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module emg_impulse_detector_test;

   localparam logic [eid_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [eid_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASES       = 10;
   localparam int PHASE_FRAMES = 125;
   localparam int PEND_SLOTS   = 2048;
   localparam int DRILL_SLOTS  = 64;

   typedef struct {
      bit                            is_write;
      logic [eid_pkg::CSR_IDX_W-1:0] reg_sel;
      logic [eid_pkg::CSR_W-1:0]     reg_val;
      eid_pkg::eid_req_type          frame;
      bit                            typed;
      eid_pkg::eid_rsp_type          want;
   } drill_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   eid_pkg::eid_req_type          req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   eid_pkg::eid_rsp_type          rsp_data;
   logic                          csr_wr_en = 1'b0;
   logic [eid_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [eid_pkg::CSR_W-1:0]     csr_wdata = '0;

   // envelope predictor state
   int win_mag [eid_pkg::WINDOW_LEN][eid_pkg::CHANNELS];
   int chan_total [eid_pkg::CHANNELS];
   int frames_held, next_slot;
   bit rise_on, fall_on;
   int rise_left, fall_left, rise_dbc, fall_dbc;
   int lvl_rise_hi, lvl_rise_lo, lvl_fall_hi, lvl_fall_lo, pulse_frames, debounce_len;

   // expected words in order, as a ring with head and tail counts
   eid_pkg::eid_rsp_type pending_pulses [PEND_SLOTS];
   int                   pend_head = 0;
   int                   pend_tail = 0;
   drill_row_type        drill [DRILL_SLOTS];
   int                   drill_rows = 0;
   int                   mismatches = 0;
   int                   words_seen = 0;
   int                   cycle_count = 0;
   int                   rsp_wait = 0;
   int                   hold_off = 0;
   bit                   calm = 1'b0;
   bit                   rush = 1'b0;
   eid_pkg::eid_rsp_type want_word;

   emg_impulse_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void restart_envelope();
      foreach (win_mag[s, c]) win_mag[s][c] = 0;
      foreach (chan_total[c]) chan_total[c] = 0;
      frames_held = 0;
      next_slot = 0;
      rise_on = 1'b0;
      fall_on = 1'b0;
      rise_left = 0;
      fall_left = 0;
      lvl_rise_hi = int'(eid_pkg::RISE_HIGH_RST);
      lvl_rise_lo = int'(eid_pkg::RISE_LOW_RST);
      lvl_fall_hi = int'(eid_pkg::FALL_HIGH_RST);
      lvl_fall_lo = int'(eid_pkg::FALL_LOW_RST);
      pulse_frames = int'(eid_pkg::PULSE_LEN_RST);
      debounce_len = int'(eid_pkg::DEBOUNCE_RST);
      rise_dbc = debounce_len;
      fall_dbc = debounce_len;
   endfunction

   function automatic eid_pkg::eid_rsp_type envelope_step(eid_pkg::eid_req_type f);
      logic [63:0]          samples;
      logic signed [7:0]    s;
      int                   mag, peak, lhs, slot;
      bit                   rise_out, fall_out;
      eid_pkg::eid_rsp_type r;
      samples = {f.chan7, f.chan6, f.chan5, f.chan4, f.chan3, f.chan2, f.chan1, f.chan0};
      slot = next_slot;
      peak = 0;
      for (int c = 0; c < eid_pkg::CHANNELS; c++) begin
         s = samples[8*c +: 8];
         mag = (s < 0) ? -int'(s) : int'(s);
         if (frames_held >= eid_pkg::WINDOW_LEN) chan_total[c] -= win_mag[slot][c];
         chan_total[c] += mag;
         win_mag[slot][c] = mag;
         if (chan_total[c] > peak) peak = chan_total[c];
      end
      next_slot = (slot + 1) % eid_pkg::WINDOW_LEN;
      if (frames_held < eid_pkg::WINDOW_LEN) frames_held++;
      lhs = peak * 16;
      rise_out = 1'b0;
      fall_out = 1'b0;

      if (!rise_on && lhs > lvl_rise_hi * frames_held && !f.posing) begin
         rise_on = 1'b1;
         rise_left = pulse_frames;
      end
      if (rise_on && rise_left > 0) begin
         rise_out = 1'b1;
         rise_left--;
      end
      if (rise_left == 0 && lhs <= lvl_rise_lo * frames_held) rise_on = 1'b0;

      if (lhs >= lvl_fall_hi * frames_held) begin
         if (rise_dbc > 0) rise_dbc--;
      end else begin
         rise_dbc = debounce_len;
      end
      if (rise_dbc == 0) fall_on = 1'b1;
      if (lhs <= lvl_fall_lo * frames_held) begin
         if (fall_dbc > 0) fall_dbc--;
      end else begin
         fall_dbc = debounce_len;
      end
      if (fall_on && fall_dbc == 0) begin
         fall_on = 1'b0;
         fall_left = pulse_frames;
      end
      if (!fall_on && fall_left > 0) begin
         fall_out = 1'b1;
         fall_left--;
      end

      r.impulse = rise_out | fall_out;
      r.rising_pulse = rise_out;
      r.falling_pulse = fall_out;
      return r;
   endfunction

   function automatic void add_frame(eid_pkg::eid_req_type f);
      drill[drill_rows] = '{1'b0, '0, '0, f, 1'b0, '0};
      drill_rows++;
   endfunction

   function automatic void add_typed(eid_pkg::eid_req_type f, eid_pkg::eid_rsp_type w);
      drill[drill_rows] = '{1'b0, '0, '0, f, 1'b1, w};
      drill_rows++;
   endfunction

   function automatic void add_write(logic [eid_pkg::CSR_IDX_W-1:0] idx,
                                     logic [eid_pkg::CSR_W-1:0] val);
      drill[drill_rows] = '{1'b1, idx, val, '0, 1'b0, '0};
      drill_rows++;
   endfunction

   function automatic eid_pkg::eid_req_type flat_frame(logic [7:0] v, bit pose);
      return {v, v, v, v, v, v, v, v, pose};
   endfunction

   function automatic eid_pkg::eid_req_type noisy_frame(int loud, logic [7:0] hot, bit pose);
      logic [63:0] s;
      int          m, lim;
      for (int c = 0; c < 8; c++) begin
         lim = hot[c] ? loud : 4;
         if ($urandom_range(0, 24) == 0) begin
            s[8*c +: 8] = 8'($urandom_range(0, 255));
         end else begin
            m = $urandom_range(0, lim);
            if ($urandom_range(0, 1)) s[8*c +: 8] = 8'(-m);
            else s[8*c +: 8] = 8'((m > 127) ? 127 : m);
         end
      end
      return {s[7:0], s[15:8], s[23:16], s[31:24], s[39:32], s[47:40], s[55:48],
              s[63:56], pose};
   endfunction

   function automatic int draw_level();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 2048;
         default: return $urandom_range(64, 1500);
      endcase
   endfunction

   function automatic int draw_frames();
      case ($urandom_range(0, 11))
         0: return 255;
         1: return 1;
         2: return 0;
         default: return $urandom_range(2, 24);
      endcase
   endfunction

   // leaves the write enable high so back-to-back writes need no re-raise
   task automatic write_reg(logic [eid_pkg::CSR_IDX_W-1:0] idx,
                            logic [eid_pkg::CSR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         eid_pkg::REG_RISE_HIGH: lvl_rise_hi = int'(val);
         eid_pkg::REG_RISE_LOW:  lvl_rise_lo = int'(val);
         eid_pkg::REG_FALL_HIGH: lvl_fall_hi = int'(val);
         eid_pkg::REG_FALL_LOW:  lvl_fall_lo = int'(val);
         eid_pkg::REG_PULSE_LEN: pulse_frames = int'(val[7:0]);
         eid_pkg::REG_DEBOUNCE:  debounce_len = int'(val[7:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_frame(eid_pkg::eid_req_type f, bit typed, eid_pkg::eid_rsp_type w);
      int                   gap;
      eid_pkg::eid_rsp_type p;
      gap = rush ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = envelope_step(f);
      pending_pulses[pend_tail % PEND_SLOTS] = typed ? w : p;
      pend_tail++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pend_head != pend_tail) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: checking, random stall and long hold-offs
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (pend_head == pend_tail) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %b at cycle %0d", rsp_data, cycle_count);
            end else begin
               want_word = pending_pulses[pend_head % PEND_SLOTS];
               pend_head++;
               if (rsp_data.impulse !== want_word.impulse ||
                   rsp_data.rising_pulse !== want_word.rising_pulse ||
                   rsp_data.falling_pulse !== want_word.falling_pulse) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: impulse/rise/fall expected %b%b%b got %b%b%b",
                              words_seen, want_word.impulse, want_word.rising_pulse,
                              want_word.falling_pulse, rsp_data.impulse,
                              rsp_data.rising_pulse, rsp_data.falling_pulse);
               end
            end
            rsp_wait = calm ? 0 : $urandom_range(0, 6);
            if (words_seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            if (words_seen == 200 || words_seen == 700) hold_off = 80;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int   sent, seg_len, loud, hi, lo;
      logic [7:0] hot;
      bit   pose;
      restart_envelope();

      // single loud frame after reset: level 2048 above the default rise level
      add_typed(flat_frame(8'h80, 1'b0), 3'b110);
      add_frame(flat_frame(8'h7f, 1'b1));
      add_frame(flat_frame(8'h00, 1'b0));
      add_frame({8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
      add_frame({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 1'b1});
      // zero pulse length and zero debounce
      add_write(eid_pkg::REG_PULSE_LEN, 12'd0);
      add_write(eid_pkg::REG_DEBOUNCE, 12'd0);
      add_frame(flat_frame(8'h80, 1'b0));
      add_frame(flat_frame(8'h00, 1'b0));
      add_frame(flat_frame(8'h00, 1'b0));
      add_write(eid_pkg::REG_RISE_HIGH, 12'd0);
      add_write(eid_pkg::REG_RISE_LOW, 12'd2048);
      add_write(eid_pkg::REG_FALL_HIGH, 12'd0);
      add_write(eid_pkg::REG_FALL_LOW, 12'd2048);
      add_frame(flat_frame(8'h00, 1'b0));
      add_frame(flat_frame(8'h01, 1'b0));
      add_frame(flat_frame(8'h80, 1'b1));
      // masked values and writes to unused indexes
      add_write(eid_pkg::REG_PULSE_LEN, 12'hf03);
      add_write(eid_pkg::REG_DEBOUNCE, 12'hf02);
      add_write(eid_pkg::REG_RISE_HIGH, 12'hfff);
      add_write(REG_SPARE_LO, 12'habc);
      add_write(REG_SPARE_HI, 12'h555);
      add_frame(flat_frame(8'h80, 1'b0));
      add_frame(flat_frame(8'h00, 1'b1));
      add_frame(flat_frame(8'h81, 1'b0));
      add_write(eid_pkg::REG_RISE_HIGH, 12'd2048);
      add_write(eid_pkg::REG_RISE_LOW, 12'd0);
      add_write(eid_pkg::REG_FALL_HIGH, 12'd2048);
      add_write(eid_pkg::REG_FALL_LOW, 12'd0);
      add_write(eid_pkg::REG_PULSE_LEN, 12'd255);
      add_write(eid_pkg::REG_DEBOUNCE, 12'd255);
      add_frame(flat_frame(8'h80, 1'b0));
      add_frame(flat_frame(8'h00, 1'b0));
      add_frame({8'h7f, 8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80, 1'b0});

      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < drill_rows; i++) begin
         if (drill[i].is_write) begin
            if (i == 0 || !drill[i-1].is_write) settle();
            write_reg(drill[i].reg_sel, drill[i].reg_val);
         end else begin
            if (i > 0 && drill[i-1].is_write) csr_wr_en <= 1'b0;
            send_frame(drill[i].frame, drill[i].typed, drill[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         hi = draw_level();
         lo = ($urandom_range(0, 7) == 0) ? draw_level() : $urandom_range(0, hi);
         write_reg(eid_pkg::REG_RISE_HIGH, 12'(hi));
         write_reg(eid_pkg::REG_RISE_LOW, 12'(lo));
         hi = draw_level();
         lo = ($urandom_range(0, 7) == 0) ? draw_level() : $urandom_range(0, hi);
         write_reg(eid_pkg::REG_FALL_HIGH, 12'(hi));
         write_reg(eid_pkg::REG_FALL_LOW, 12'(lo));
         write_reg(eid_pkg::REG_PULSE_LEN, {4'($urandom_range(0, 15)), 8'(draw_frames())});
         write_reg(eid_pkg::REG_DEBOUNCE, {4'($urandom_range(0, 15)), 8'(draw_frames())});
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      12'($urandom_range(0, 4095)));
         csr_wr_en <= 1'b0;
         rush = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_FRAMES) begin
            seg_len = $urandom_range(3, 40);
            case ($urandom_range(0, 2))
               0: loud = $urandom_range(0, 6);
               1: loud = $urandom_range(20, 60);
               default: loud = $urandom_range(100, 128);
            endcase
            hot = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
            pose = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0) rush = ~rush;
            for (int k = 0; k < seg_len && sent < PHASE_FRAMES; k++) begin
               if ($urandom_range(0, 15) == 0) pose = ~pose;
               send_frame(noisy_frame(loud, hot, pose), 1'b0, '0);
               sent++;
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
